@@ hdl/bgr555_color_adjust_assert.svh @@
// Assertion macros for the color adjust block.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef BGR555_COLOR_ADJUST_ASSERT_SVH
`define BGR555_COLOR_ADJUST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BCA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/bca_pkg.sv @@
`default_nettype none

package bca_pkg;

	typedef logic [7:0] chan_t;
	// channel 0 is red, 1 green, 2 blue
	typedef chan_t [2:0] pix_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_OUT_FORMAT  = 3'd0,
		REG_CONTRAST    = 3'd1,
		REG_BRIGHTNESS  = 3'd2,
		REG_GAMMA_EN    = 3'd3,
		REG_RAMP_EN     = 3'd4,
		REG_SEPIA_EN    = 3'd5,
		REG_GRAY_EN     = 3'd6,
		REG_INVERT_EN   = 3'd7
	} reg_idx_t;

	// output packing formats
	typedef enum logic [1:0] {
		FMT_RGB555 = 2'd0,
		FMT_RGB565 = 2'd1,
		FMT_RGB888 = 2'd2,
		FMT_NONE   = 2'd3
	} fmt_t;

	typedef struct packed {
		fmt_t               out_format;
		logic signed [8:0]  contrast;
		logic signed [8:0]  brightness;
		logic               gamma_en;
		logic               ramp_en;
		logic               sepia_en;
		logic               gray_en;
		logic               invert_en;
	} cfg_t;

	// gamma curve write, broadcast to every lane copy of the curve
	typedef struct packed {
		logic  we;
		chan_t addr;
		chan_t data;
	} curve_wr_t;

	localparam int unsigned CURVE_DEPTH = 256;

	// 2^24 / 255 rounded down; the estimate is low by at most one
	localparam logic [16:0] DIV255_RECIP = 17'd65793;

	// Q16 luma and sepia weights
	localparam logic [15:0] LUMA_KR = 16'd13933;
	localparam logic [15:0] LUMA_KG = 16'd46871;
	localparam logic [15:0] LUMA_KB = 16'd4732;
	localparam logic [16:0] SEPIA_KR = 17'd85197;
	localparam logic [16:0] SEPIA_KG = 17'd61932;
	localparam logic [16:0] SEPIA_KB = 17'd50791;

	// fixed 32-entry gamma ramp
	function automatic chan_t ramp_lookup(input logic [4:0] idx);
		chan_t r;
		case (idx)
			5'd0:  r = 8'h00;
			5'd1:  r = 8'h01;
			5'd2:  r = 8'h03;
			5'd3:  r = 8'h06;
			5'd4:  r = 8'h0a;
			5'd5:  r = 8'h0f;
			5'd6:  r = 8'h15;
			5'd7:  r = 8'h1c;
			5'd8:  r = 8'h24;
			5'd9:  r = 8'h2d;
			5'd10: r = 8'h37;
			5'd11: r = 8'h42;
			5'd12: r = 8'h4e;
			5'd13: r = 8'h5b;
			5'd14: r = 8'h69;
			5'd15: r = 8'h78;
			5'd16: r = 8'h88;
			5'd17: r = 8'h90;
			5'd18: r = 8'h98;
			5'd19: r = 8'ha0;
			5'd20: r = 8'ha8;
			5'd21: r = 8'hb0;
			5'd22: r = 8'hb8;
			5'd23: r = 8'hc0;
			5'd24: r = 8'hc8;
			5'd25: r = 8'hd0;
			5'd26: r = 8'hd8;
			5'd27: r = 8'he0;
			5'd28: r = 8'he8;
			5'd29: r = 8'hf0;
			5'd30: r = 8'hf8;
			default: r = 8'hff;
		endcase
		return r;
	endfunction

	// clamp a signed intermediate to 0..255
	function automatic chan_t sat_u8(input logic signed [11:0] v);
		chan_t r;
		if (v < 12'sd0) begin
			r = 8'd0;
		end else if (v > 12'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// sum of the three weighted channels, Q16 down to 8 bits with clamp
	function automatic chan_t luma_sum(input logic [23:0] pr, input logic [23:0] pg,
			input logic [23:0] pb);
		logic [25:0] s;
		logic [9:0]  l;
		s = 26'(pr) + 26'(pg) + 26'(pb);
		l = s[25:16];
		return (l > 10'd255) ? 8'd255 : l[7:0];
	endfunction

	// Q16 scale of a luma value with clamp
	function automatic chan_t sepia_scale(input chan_t l, input logic [16:0] k);
		logic [24:0] p;
		p = 25'(l) * 25'(k);
		return (p[24:16] > 9'd255) ? 8'd255 : p[23:16];
	endfunction

endpackage

`default_nettype wire

@@ hdl/bca_ram.sv @@
`default_nettype none

module bca_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/bca_lane.sv @@
`default_nettype none

module bca_lane import bca_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire cfg_t              cfg,
	input  wire logic [4:0]        chan_in,
	input  wire curve_wr_t         wr,
	output chan_t                  chan_out
);

	chan_t              x_s1, x_s2, x_s3, x_s4;
	logic [16:0]        mag_s2, mag_s3;
	logic               neg_s2, neg_s3;
	logic [9:0]         q_s3;
	logic signed [10:0] qs_s4;
	chan_t              v_s5, v_s6, v_s7;
	chan_t              curve_rd;

	logic signed [18:0] prod;
	logic [33:0]        est;
	logic [17:0]        rem;
	logic [9:0]         q_fix;
	logic signed [11:0] con_sum;
	logic signed [11:0] bri_sum;

	// contrast numerator 2*c*x + 127, split into sign and magnitude
	always_comb begin
		prod = 19'(cfg.contrast) * 19'(signed'({1'b0, x_s1})) * 19'sd2 + 19'sd127;
	end

	// quotient estimate by reciprocal multiply
	assign est = 34'(mag_s2) * 34'(DIV255_RECIP);

	// fix the estimate up by one where the remainder reaches 255
	always_comb begin
		rem   = 18'(mag_s3) - ((18'(q_s3) << 8) - 18'(q_s3));
		q_fix = q_s3 + 10'(rem >= 18'd255);
	end

	assign con_sum = 12'(signed'({1'b0, x_s4})) - 12'(cfg.contrast) + 12'(qs_s4);
	assign bri_sum = 12'(signed'({1'b0, v_s5})) + 12'(cfg.brightness);

	always_ff @(posedge clk) begin
		if (en) begin
			// widen by bit replication or map through the ramp
			x_s1   <= cfg.ramp_en ? ramp_lookup(chan_in) : {chan_in, chan_in[4:2]};
			x_s2   <= x_s1;
			neg_s2 <= prod[18];
			mag_s2 <= prod[18] ? 17'(-prod) : 17'(prod);
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			q_s3   <= est[33:24];
			x_s4   <= x_s3;
			qs_s4  <= neg_s3 ? -signed'({1'b0, q_fix}) : signed'({1'b0, q_fix});
			v_s5   <= sat_u8(con_sum);
			v_s6   <= sat_u8(bri_sum);
			v_s7   <= v_s6;
		end
	end

	// gamma curve copy; writes and reads both issue from stage 6, in item order
	bca_ram #(
		.WIDTH (8),
		.DEPTH (CURVE_DEPTH)
	) u_curve (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (en),
		.raddr (v_s6),
		.rdata (curve_rd)
	);

	assign chan_out = cfg.gamma_en ? curve_rd : v_s7;

endmodule

`default_nettype wire

@@ hdl/bca_tone.sv @@
`default_nettype none

module bca_tone import bca_pkg::*; (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire cfg_t         cfg,
	input  wire pix_t         ch_in,
	output logic [31:0]       color
);

	pix_t        ch_s8, ch_s9, ch_s10, ch_s11, ch_s12;
	logic [23:0] pr_s8, pg_s8, pb_s8;
	logic [23:0] pr_s11, pg_s11, pb_s11;
	chan_t       l_s9;
	chan_t       l2;
	pix_t        sep;
	pix_t        fin;

	// sepia tint of the first luma
	always_comb begin
		sep[0] = sepia_scale(l_s9, SEPIA_KR);
		sep[1] = sepia_scale(l_s9, SEPIA_KG);
		sep[2] = sepia_scale(l_s9, SEPIA_KB);
	end

	assign l2 = luma_sum(pr_s11, pg_s11, pb_s11);

	always_ff @(posedge clk) begin
		if (en) begin
			// luma products of the adjusted color
			ch_s8  <= ch_in;
			pr_s8  <= 24'(ch_in[0]) * 24'(LUMA_KR);
			pg_s8  <= 24'(ch_in[1]) * 24'(LUMA_KG);
			pb_s8  <= 24'(ch_in[2]) * 24'(LUMA_KB);
			ch_s9  <= ch_s8;
			l_s9   <= luma_sum(pr_s8, pg_s8, pb_s8);
			ch_s10 <= cfg.sepia_en ? sep : ch_s9;
			// gray takes luma of whatever sepia left
			ch_s11 <= ch_s10;
			pr_s11 <= 24'(ch_s10[0]) * 24'(LUMA_KR);
			pg_s11 <= 24'(ch_s10[1]) * 24'(LUMA_KG);
			pb_s11 <= 24'(ch_s10[2]) * 24'(LUMA_KB);
			ch_s12 <= cfg.gray_en ? {l2, l2, l2} : ch_s11;
		end
	end

	// inversion and output packing
	always_comb begin
		fin = cfg.invert_en ? (ch_s12 ^ {3{8'hff}}) : ch_s12;
		case (cfg.out_format)
			FMT_RGB555: color = {17'd0, fin[0][7:3], fin[1][7:3], fin[2][7:3]};
			FMT_RGB565: color = {16'd0, fin[0][7:3], fin[1][7:2], fin[2][7:3]};
			FMT_RGB888: color = {8'd0, fin[0], fin[1], fin[2]};
			default:    color = 32'hffff_ffff;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/bgr555_color_adjust.sv @@
// A pixel word passes the lane stages, the tone stages and the output register to m_tvalid.
// Throughput: one word and one curve read per lane per cycle while the skid entry is empty.
// A curve write word produces no output word and takes the same slot as a pixel.
// Reset (arst_n low, asynchronous) clears all valid flags and loads register defaults;
// the gamma curve holds no defined value until written.
`default_nettype none

`include "bgr555_color_adjust_assert.svh"

module bgr555_color_adjust import bca_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration writes
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [8:0]   cfg_data,
	// input words
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,  // pixel_in[14:0], curve_index[22:15], curve_value[30:23]
	input  wire logic         s_tuser,  // cmd: 0 convert, 1 curve write
	// output words
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata   // color_out[31:0]
);

	cfg_t         cfg_q;
	logic         en;
	logic [12:1]  px_vld_s;
	logic [6:1]   wr_vld_s;
	chan_t        idx_s [6:1];
	chan_t        val_s [6:1];
	curve_wr_t    curve_wr;
	pix_t         lane_out;
	logic [31:0]  res_data;
	logic         res_vld;
	logic         out_vld_q, skid_vld_q;
	logic [31:0]  out_data_q, skid_data_q;
	logic         pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{out_format: FMT_RGB888, contrast: '0, brightness: '0,
				gamma_en: 1'b0, ramp_en: 1'b0, sepia_en: 1'b0, gray_en: 1'b0,
				invert_en: 1'b0};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OUT_FORMAT: cfg_q.out_format <= fmt_t'(cfg_data[1:0]);
				REG_CONTRAST:   cfg_q.contrast   <= signed'(cfg_data);
				REG_BRIGHTNESS: cfg_q.brightness <= signed'(cfg_data);
				REG_GAMMA_EN:   cfg_q.gamma_en   <= cfg_data[0];
				REG_RAMP_EN:    cfg_q.ramp_en    <= cfg_data[0];
				REG_SEPIA_EN:   cfg_q.sepia_en   <= cfg_data[0];
				REG_GRAY_EN:    cfg_q.gray_en    <= cfg_data[0];
				REG_INVERT_EN:  cfg_q.invert_en  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the skid stage holds a word
	assign en       = !skid_vld_q;
	assign s_tready = en;

	// per-stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_vld_s <= '0;
			wr_vld_s <= '0;
		end else if (en) begin
			px_vld_s <= {px_vld_s[11:1], s_tvalid && !s_tuser};
			wr_vld_s <= {wr_vld_s[5:1], s_tvalid && s_tuser};
		end
	end

	// curve write fields ride along to stage 6
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s[1] <= s_tdata[22:15];
			val_s[1] <= s_tdata[30:23];
			for (int i = 2; i <= 6; i++) begin
				idx_s[i] <= idx_s[i-1];
				val_s[i] <= val_s[i-1];
			end
		end
	end

	assign curve_wr = '{we: wr_vld_s[6] && en, addr: idx_s[6], data: val_s[6]};

	// one lane per channel, each with its own curve copy
	for (genvar k = 0; k < 3; k++) begin : g_lane
		bca_lane u_lane (
			.clk      (clk),
			.en       (en),
			.cfg      (cfg_q),
			.chan_in  (s_tdata[5*k +: 5]),
			.wr       (curve_wr),
			.chan_out (lane_out[k])
		);
	end

	bca_tone u_tone (
		.clk   (clk),
		.en    (en),
		.cfg   (cfg_q),
		.ch_in (lane_out),
		.color (res_data)
	);

	assign res_vld = px_vld_s[12] && en;
	assign pop     = out_vld_q && m_tready;

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (res_vld) begin
			if (out_vld_q && !m_tready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (res_vld) begin
			if (out_vld_q && !m_tready) begin
				skid_data_q <= res_data;
			end else begin
				out_data_q <= res_data;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// skid entry is only used behind a full output register
	`BCA_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_vld_q, out_vld_q)
	// a held skid word is not lost without a pop
	`BCA_ASSERT_NEXT(a_skid_holds, clk, arst_n, skid_vld_q && !m_tready, skid_vld_q)
	// a result arriving at a stalled output goes to the skid entry
	`BCA_ASSERT_NEXT(a_res_to_skid, clk, arst_n, res_vld && out_vld_q && !m_tready,
		skid_vld_q && out_vld_q)
	// a stage never carries a pixel and a curve write at once
	`BCA_ASSERT_IMP(a_kind_excl, clk, arst_n, wr_vld_s[6], !px_vld_s[6])

endmodule

`default_nettype wire

@@ bench/bgr555_color_adjust_tb.sv @@
`default_nettype none

module bgr555_color_adjust_tb;
	import bca_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// one input word as the sender sees it
	typedef struct {
		bit          cmd;     // 1 loads a gamma curve entry
		logic [14:0] pixel;
		logic [7:0]  cidx;
		logic [7:0]  cval;
		bit          drain;   // hold this word back until all colors are out
	} in_word_t;

	// fixed gamma ramp, indexed by the top five bits of a channel
	localparam logic [7:0] RAMP_TBL [32] = '{
		8'h00, 8'h01, 8'h03, 8'h06, 8'h0a, 8'h0f, 8'h15, 8'h1c,
		8'h24, 8'h2d, 8'h37, 8'h42, 8'h4e, 8'h5b, 8'h69, 8'h78,
		8'h88, 8'h90, 8'h98, 8'ha0, 8'ha8, 8'hb0, 8'hb8, 8'hc0,
		8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8, 8'hff
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [8:0]  cfg_data = 9'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;   // pixel_in[14:0], curve_index[22:15], curve_value[30:23]
	logic        s_tuser = 1'b0;    // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // color_out[31:0]

	// predictor state: register copy and gamma curve copy
	cfg_t        cfg_mdl;
	logic [7:0]  curve_mdl [256];

	in_word_t    pend [$];
	logic [31:0] color_due [$];
	int          errs = 0;
	int          burst_cnt = 1;
	int          gap_cnt = 0;

	bgr555_color_adjust DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic int clip8(input int v);
		if (v < 0) return 0;
		if (v > 255) return 255;
		return v;
	endfunction

	function automatic int luma8(input int r, input int g, input int b);
		int l;
		l = (r * 13933 + g * 46871 + b * 4732) >>> 16;
		return (l > 255) ? 255 : l;
	endfunction

	function automatic logic [31:0] adjust_color(input logic [14:0] px);
		int         ch [3];
		int         v, c, l;
		logic [7:0] r8, g8, b8;
		logic [31:0] res;
		for (int k = 0; k < 3; k++) begin
			// widen 5 bits to 8 by replicating the top bits
			v = int'(px[5*k +: 5]);
			v = (v << 3) | (v >> 2);
			if (cfg_mdl.ramp_en)
				v = int'(RAMP_TBL[v >> 3]);
			if (cfg_mdl.contrast != 0) begin
				c = int'(cfg_mdl.contrast);
				v = clip8(v - c + (2 * c * v + 127) / 255);
			end
			if (cfg_mdl.brightness != 0)
				v = clip8(v + int'(cfg_mdl.brightness));
			if (cfg_mdl.gamma_en)
				v = int'(curve_mdl[v]);
			ch[k] = v;
		end
		// sepia first, then gray takes luma of whatever is there
		if (cfg_mdl.sepia_en) begin
			l = luma8(ch[0], ch[1], ch[2]);
			ch[0] = clip8((l * 85197) >>> 16);
			ch[1] = clip8((l * 61932) >>> 16);
			ch[2] = clip8((l * 50791) >>> 16);
		end
		if (cfg_mdl.gray_en) begin
			l = luma8(ch[0], ch[1], ch[2]);
			ch[0] = l;
			ch[1] = l;
			ch[2] = l;
		end
		r8 = ch[0][7:0];
		g8 = ch[1][7:0];
		b8 = ch[2][7:0];
		if (cfg_mdl.invert_en) begin
			r8 = ~r8;
			g8 = ~g8;
			b8 = ~b8;
		end
		case (cfg_mdl.out_format)
			FMT_RGB555: res = {17'd0, r8[7:3], g8[7:3], b8[7:3]};
			FMT_RGB565: res = {16'd0, r8[7:3], g8[7:2], b8[7:3]};
			FMT_RGB888: res = {8'd0, r8, g8, b8};
			default:    res = 32'hffff_ffff;
		endcase
		return res;
	endfunction

	// account for one accepted input word
	task automatic apply_word(input logic cmd, input logic [31:0] d);
		if (cmd)
			curve_mdl[d[22:15]] = d[30:23];
		else
			color_due.push_back(adjust_color(d[14:0]));
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s: got %h want %h", $realtime, what, got, want);
		errs++;
	endtask

	// ---------------------------------------------------------------
	// driver: bursts of words with random gaps
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		in_word_t w;
		bit hold;
		bit go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_word(s_tuser, s_tdata);
			end
			hold = s_tvalid && !s_tready;
			if (!hold) begin
				go = 1'b0;
				if (gap_cnt != 0)
					gap_cnt--;
				else if (pend.size() != 0 && !(pend[0].drain && color_due.size() != 0))
					go = 1'b1;
				if (go) begin
					w = pend.pop_front();
					s_tuser <= w.cmd;
					s_tdata <= {1'b0, w.cval, w.cidx, w.pixel};
					burst_cnt--;
					if (burst_cnt == 0) begin
						burst_cnt = $urandom_range(1, 40);
						gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_tvalid <= go;
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: ready follows a 32-bit pattern, redrawn each lap
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		static logic [31:0] rdy_pat = '1;
		static int rdy_pos = 0;
		if (rdy_pos == 0) begin
			case ($urandom_range(0, 3))
				0:       rdy_pat = '1;
				1:       rdy_pat = $urandom;
				default: rdy_pat = $urandom | $urandom;
			endcase
			rdy_pat[0] = 1'b1;
		end
		m_tready <= rdy_pat[rdy_pos];
		rdy_pos = (rdy_pos + 1) % 32;
	end

	// ---------------------------------------------------------------
	// monitor: each output word against the oldest predicted color
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (color_due.size() == 0) begin
				report("unexpected output word", m_tdata, 32'd0);
			end else begin
				want = color_due.pop_front();
				if (m_tdata !== want)
					report("color_out mismatch", m_tdata, want);
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	task automatic push_pixel(input logic [14:0] px, input bit drain = 1'b0);
		in_word_t w;
		w.cmd = 1'b0;
		w.pixel = px;
		w.cidx = 8'($urandom);
		w.cval = 8'($urandom);
		w.drain = drain;
		pend.push_back(w);
	endtask

	task automatic push_curve(input logic [7:0] idx, input logic [7:0] val);
		in_word_t w;
		w.cmd = 1'b1;
		w.pixel = 15'($urandom);
		w.cidx = idx;
		w.cval = val;
		w.drain = 1'b0;
		pend.push_back(w);
	endtask

	// block idle: nothing queued, nothing in flight, curve writes settled;
	// checked between edges so the driver's last word is seen
	task automatic wait_idle();
		while (pend.size() != 0 || s_tvalid || color_due.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [8:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
	endtask

	// write every register; the copy is updated up front since the block is idle
	task automatic program_regs(input fmt_t f, input int con, input int bri,
			input bit gam, input bit rmp, input bit sep, input bit gry, input bit inv);
		wait_idle();
		cfg_mdl.out_format = f;
		cfg_mdl.contrast   = 9'(con);
		cfg_mdl.brightness = 9'(bri);
		cfg_mdl.gamma_en   = gam;
		cfg_mdl.ramp_en    = rmp;
		cfg_mdl.sepia_en   = sep;
		cfg_mdl.gray_en    = gry;
		cfg_mdl.invert_en  = inv;
		put_reg(REG_OUT_FORMAT, {7'd0, f});
		put_reg(REG_CONTRAST,   cfg_mdl.contrast);
		put_reg(REG_BRIGHTNESS, cfg_mdl.brightness);
		put_reg(REG_GAMMA_EN,   {8'd0, gam});
		put_reg(REG_RAMP_EN,    {8'd0, rmp});
		put_reg(REG_SEPIA_EN,   {8'd0, sep});
		put_reg(REG_GRAY_EN,    {8'd0, gry});
		put_reg(REG_INVERT_EN,  {8'd0, inv});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// signed setting: often an extreme, otherwise anywhere in range
	function automatic int pick_level();
		case ($urandom_range(0, 7))
			0:       return -256;
			1:       return -255;
			2:       return 255;
			3:       return 0;
			default: return int'($urandom_range(0, 511)) - 256;
		endcase
	endfunction

	// random pixel, sometimes with channels pinned at their ends
	function automatic logic [14:0] pick_pixel();
		logic [14:0] px;
		px = 15'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 2))
					0: px[5*k +: 5] = 5'd0;
					1: px[5*k +: 5] = 5'd31;
					default: ;
				endcase
			end
		end
		return px;
	endfunction

	initial begin
		fmt_t f;
		cfg_mdl = '{out_format: FMT_RGB888, default: '0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: plain widening into rgb888
		push_pixel(15'h0000);
		push_pixel(15'h7fff);
		push_pixel(15'h001f);
		push_pixel(15'h03e0);
		push_pixel(15'h7c00);
		push_pixel(15'h5555);
		push_pixel(15'h2aaa);
		push_curve(8'h00, 8'h00);
		push_curve(8'hff, 8'hff);

		// fill the whole gamma curve before it is ever enabled
		for (int i = 0; i < 256; i++)
			push_curve(i[7:0], ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom));

		// unsupported format gives all ones
		program_regs(FMT_NONE, 0, 0, 0, 0, 0, 0, 0);
		push_pixel(15'h7fff);
		push_pixel(15'h0000);

		// contrast at its negative end
		program_regs(FMT_RGB555, -256, 0, 0, 0, 0, 0, 0);
		push_pixel(15'h7fff);
		push_pixel(15'h4210);
		push_pixel(15'h0000);

		// brightness at its negative end over full contrast
		program_regs(FMT_RGB565, 255, -256, 0, 0, 0, 0, 0);
		push_pixel(15'h7fff);
		push_pixel(15'h1234);

		// ramp, full contrast and brightness
		program_regs(FMT_RGB888, 255, 255, 0, 1, 0, 0, 0);
		push_pixel(15'h4a52);
		push_pixel(15'h0421);

		// sepia and gray together, through the curve and inverted
		program_regs(FMT_RGB565, -255, 0, 1, 0, 1, 1, 1);
		push_pixel(15'h7fff);
		push_pixel(15'h03ff);

		// random phases, one format per phase in turn
		for (int ph = 0; ph < 8; ph++) begin
			f = fmt_t'(ph % 4);
			program_regs(f, pick_level(), pick_level(), $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1));
			for (int i = 0; i < 35; i++) begin
				if ($urandom_range(0, 7) == 0)
					push_curve(8'($urandom), 8'($urandom));
				else
					push_pixel(pick_pixel(),
						(ph == 2 && i == 17) || $urandom_range(0, 39) == 0);
			end
		end

		// drain and settle
		while (pend.size() != 0 || s_tvalid || color_due.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (errs == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/bca_pkg.sv
hdl/bca_ram.sv
hdl/bca_lane.sv
hdl/bca_tone.sv
hdl/bgr555_color_adjust.sv
bench/bgr555_color_adjust_tb.sv
